// ----- hdl/lss_pkg.sv -----
// Shared types, constants and helpers for the literal substring scanner.
// Used by lss_matcher and the scanner top level; depends on nothing else.
package lss_pkg;

    localparam int NEEDLE_MAX     = 32;
    localparam int BYTE_W         = 8;
    localparam int WIN_W          = NEEDLE_MAX * BYTE_W;
    localparam int LEN_W          = 6;
    localparam int FILE_BYTES_MAX = 8388608;
    localparam int POS_W          = 24;
    localparam int OFS_W          = 23;
    localparam int LINE_W         = 24;
    localparam int LIMIT_W        = 16;
    localparam int LINE_RING      = NEEDLE_MAX + 1;
    localparam int SLOT_W         = 6;
    localparam int CFG_DW         = 64;
    localparam int CFG_AW         = 6;
    localparam int REG_IDX_W      = 3;

    localparam logic [BYTE_W-1:0]  LF_BYTE     = 8'h0A;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

    // Register indexes (byte address is eight times the index).
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LEN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FOLD_CASE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_LIM  = 3'd6;

    typedef struct packed {
        logic             equal;
        logic [LEN_W-1:0] nl_count;
    } t_cmp;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic fold);
        logic [BYTE_W-1:0] r;
        r = b;
        if (fold && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- hdl/lss_ram.sv -----
// Generic single-write, single-read RAM with a registered, read-first output.
// Stand-alone; no package needed.
module lss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/lss_matcher.sv -----
// Compares the shifted byte window with the configured needle and counts line
// feeds in the compared span. Depends on lss_pkg.
module lss_matcher import lss_pkg::*; (
    input  logic [WIN_W-1:0] i_window,
    input  logic [WIN_W-1:0] i_needle,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_fold,
    output t_cmp             o_cmp
);

    logic [WIN_W-1:0]      rev;
    logic [WIN_W-1:0]      aligned;
    logic [LEN_W-1:0]      shift_bytes;
    logic [LEN_W-1:0]      nl_count;
    logic [NEEDLE_MAX-1:0] lane_ok;

    // Reversing the needle and shifting it down by the unused length puts needle
    // byte len-1-j opposite window byte j, so the newest byte meets the last one.
    always_comb begin
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            rev[BYTE_W*i +: BYTE_W] =
                fold_byte(i_needle[BYTE_W*(NEEDLE_MAX-1-i) +: BYTE_W], i_fold);
        end
        shift_bytes = LEN_W'(NEEDLE_MAX) - i_len;
        aligned     = rev >> {shift_bytes, 3'b000};
    end

    always_comb begin
        nl_count = '0;
        for (int j = 0; j < NEEDLE_MAX; j++) begin
            if (LEN_W'(j) >= i_len) begin
                lane_ok[j] = 1'b1;
            end else begin
                lane_ok[j] = fold_byte(i_window[BYTE_W*j +: BYTE_W], i_fold)
                             == aligned[BYTE_W*j +: BYTE_W];
                if (i_window[BYTE_W*j +: BYTE_W] == LF_BYTE) begin
                    nl_count = nl_count + LEN_W'(1);
                end
            end
        end
    end

    assign o_cmp.equal    = (&lane_ok) && (i_len != '0);
    assign o_cmp.nl_count = nl_count;

endmodule

// ----- hdl/literal_substring_scanner_unit.sv -----
// Top level of the literal substring scanner: input register, scan stage,
// result register and register file. Depends on lss_pkg, lss_matcher, lss_ram.
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ---------------------------------------------
//  byte in   i_in_valid / o_in_ready  i_data_byte, i_end_of_file
//  match out o_out_valid/ i_out_ready o_match_offset, o_match_line,
//                                     o_match_line_start, o_limit_hit
//  config    psel/penable/pwrite      paddr, pwdata, prdata, pready (always high)
//
// One byte is taken every cycle unless the result stalls. A match goes from the input
// register through the scan stage to the result register; the scan outcome and the
// line start RAM read are registered at the same edge. Reset is synchronous and active
// low; it restores the register file and the per-file and global counters. A stalled
// result holds the whole pipeline, while the input register still takes one more byte.
module literal_substring_scanner_unit import lss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte in
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic                i_end_of_file,
    // match out
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFS_W-1:0]    o_match_offset,
    output logic [LINE_W-1:0]   o_match_line,
    output logic [OFS_W-1:0]    o_match_line_start,
    output logic                o_limit_hit,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    // Register file
    logic [WIN_W-1:0]     r_needle;
    logic [LEN_W-1:0]     r_needle_len;
    logic                 r_fold;
    logic [LIMIT_W-1:0]   r_limit;

    // Input register
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_eof;

    // Scan state
    logic [WIN_W-1:0]     r_window;
    logic [LEN_W-1:0]     r_fill;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     r_next_start;
    logic [LINE_W-1:0]    r_line;
    logic [SLOT_W-1:0]    r_slot;
    logic [LIMIT_W-1:0]   r_total;

    // Result register
    logic                 r_out_valid;
    logic [OFS_W-1:0]     r_offset;
    logic [LINE_W-1:0]    r_match_line;
    logic                 r_first_line;
    logic                 r_limit_hit;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 en;
    logic                 step;
    logic                 active;
    logic                 is_lf;
    logic [LEN_W-1:0]     len_c;
    logic [WIN_W-1:0]     n_window;
    logic [LEN_W-1:0]     n_fill;
    logic [POS_W-1:0]     n_pos;
    logic [LINE_W-1:0]    n_line;
    logic [SLOT_W-1:0]    n_slot;
    logic [POS_W-1:0]     start;
    logic [LINE_W-1:0]    match_line;
    logic [SLOT_W:0]      slot_diff;
    logic [SLOT_W-1:0]    rd_slot;
    logic                 hit;
    logic [LIMIT_W:0]     total_inc;
    logic [OFS_W-1:0]     ram_q;
    t_cmp                 cmp;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_AW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle     <= '0;
            r_needle_len <= '0;
            r_fold       <= 1'b1;
            r_limit      <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NEEDLE_0:   r_needle[0*CFG_DW +: CFG_DW] <= pwdata;
                REG_NEEDLE_1:   r_needle[1*CFG_DW +: CFG_DW] <= pwdata;
                REG_NEEDLE_2:   r_needle[2*CFG_DW +: CFG_DW] <= pwdata;
                REG_NEEDLE_3:   r_needle[3*CFG_DW +: CFG_DW] <= pwdata;
                REG_NEEDLE_LEN: r_needle_len <= pwdata[LEN_W-1:0];
                REG_FOLD_CASE:  r_fold       <= pwdata[0];
                REG_MATCH_LIM:  r_limit      <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_NEEDLE_0:   prdata = r_needle[0*CFG_DW +: CFG_DW];
            REG_NEEDLE_1:   prdata = r_needle[1*CFG_DW +: CFG_DW];
            REG_NEEDLE_2:   prdata = r_needle[2*CFG_DW +: CFG_DW];
            REG_NEEDLE_3:   prdata = r_needle[3*CFG_DW +: CFG_DW];
            REG_NEEDLE_LEN: prdata = CFG_DW'(r_needle_len);
            REG_FOLD_CASE:  prdata = CFG_DW'(r_fold);
            REG_MATCH_LIM:  prdata = CFG_DW'(r_limit);
            default:        prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || en;
    assign step       = en && r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    // ---------------- scan stage ----------------
    assign active = r_pos < POS_W'(FILE_BYTES_MAX);
    assign is_lf  = r_in_byte == LF_BYTE;
    assign len_c  = (r_needle_len > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : r_needle_len;

    always_comb begin
        n_window = {r_window[WIN_W-BYTE_W-1:0], r_in_byte};
        n_fill   = (r_fill == LEN_W'(NEEDLE_MAX)) ? r_fill : r_fill + LEN_W'(1);
        n_pos    = r_pos + POS_W'(1);
        n_line   = r_line + LINE_W'(is_lf);
        n_slot   = r_slot;
        if (is_lf) begin
            n_slot = (r_slot == SLOT_W'(LINE_RING - 1)) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    lss_matcher u_matcher (
        .i_window (n_window),
        .i_needle (r_needle),
        .i_len    (len_c),
        .i_fold   (r_fold),
        .o_cmp    (cmp)
    );

    always_comb begin
        start      = n_pos - POS_W'(len_c);
        match_line = n_line - LINE_W'(cmp.nl_count);
        hit        = cmp.equal && (n_fill >= len_c) && (r_total < r_limit)
                     && (start >= r_next_start);
        total_inc  = {1'b0, r_total} + (LIMIT_W+1)'(1);
        // The matched line sits nl_count entries behind the current one in the ring.
        slot_diff  = {1'b0, n_slot} - {1'b0, cmp.nl_count};
        rd_slot    = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + (SLOT_W+1)'(LINE_RING))
                                       : slot_diff[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_pos        <= '0;
            r_next_start <= '0;
            r_line       <= LINE_W'(1);
            r_slot       <= SLOT_W'(1);
            r_total      <= '0;
        end else if (step) begin
            if (active && hit) begin
                r_total <= total_inc[LIMIT_W-1:0];
            end
            if (r_in_eof) begin
                r_fill       <= '0;
                r_pos        <= '0;
                r_next_start <= '0;
                r_line       <= LINE_W'(1);
                r_slot       <= SLOT_W'(1);
            end else if (active) begin
                r_fill <= n_fill;
                r_pos  <= n_pos;
                r_line <= n_line;
                r_slot <= n_slot;
                if (hit) begin
                    r_next_start <= n_pos;
                end
            end
        end
    end

    // Bytes beyond the filled part never count toward a hit, so the window needs no clearing.
    always_ff @(posedge i_clk) begin
        if (step && active) begin
            r_window <= n_window;
        end
    end

    // Line start offsets, indexed by line number modulo the ring depth. Line one
    // always starts at zero and is never stored.
    lss_ram #(
        .WIDTH (OFS_W),
        .DEPTH (LINE_RING)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (step && active && is_lf),
        .i_wr_addr (n_slot),
        .i_wr_data (n_pos[OFS_W-1:0]),
        .i_rd_en   (en),
        .i_rd_addr (rd_slot),
        .o_rd_data (ram_q)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= step && active && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_offset     <= start[OFS_W-1:0];
            r_match_line <= match_line;
            r_first_line <= match_line == LINE_W'(1);
            r_limit_hit  <= total_inc >= {1'b0, r_limit};
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_match_offset     = r_offset;
    assign o_match_line       = r_match_line;
    assign o_match_line_start = r_first_line ? '0 : ram_q;
    assign o_limit_hit        = r_limit_hit;

endmodule
